// ===== hdl/sspd_pkg.sv =====
// Shared types, constants and codes of the six-axis serial packet decoder.
package sspd_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 64;
  localparam int STORE_DEPTH = 12;
  localparam int STORE_IDX_W = $clog2(STORE_DEPTH);
  localparam int COUNT_W = 7;
  localparam int BYTE_W = 7;
  localparam int AXIS_W = 10;
  localparam int NUM_AXES = 6;
  localparam int FLAG_W = 7;
  localparam int KEY_LEN = 9;
  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_TUSER_W = 2;

  // Packet type bytes.
  localparam logic [BYTE_W-1:0] TYPE_MOTION = 7'h44;   // 'D'
  localparam logic [BYTE_W-1:0] TYPE_KEYS = 7'h4b;     // 'K'
  localparam logic [BYTE_W-1:0] TYPE_ERROR = 7'h45;    // 'E'
  localparam logic [BYTE_W-1:0] TYPE_RESET = 7'h52;    // 'R'

  localparam logic [COUNT_W-1:0] LEN_MOTION = 7'd12;
  localparam logic [COUNT_W-1:0] LEN_KEYS = 7'd5;
  localparam logic [COUNT_W-1:0] LEN_ERROR = 7'd4;
  localparam logic [COUNT_W-1:0] LEN_MIN = 7'd2;

  // Scrambling key laid over bytes 2 to 10 of a motion packet.
  localparam logic [BYTE_W-1:0] MOTION_KEY [KEY_LEN] = '{
    7'h53, 7'h70, 7'h61, 7'h63, 7'h65, 7'h57, 7'h61, 7'h72, 7'h65
  };

  typedef enum logic [1:0] {
    KIND_MOTION = 2'd0,
    KIND_KEYS   = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_RESET  = 2'd3
  } kind_t;

  typedef logic [STORE_DEPTH-1:0][BYTE_W-1:0] store_t;

  // A packet as it stands when a start byte closes it.
  typedef struct packed {
    logic                 close;
    logic [COUNT_W-1:0]   count;
    logic [BYTE_W-1:0]    check;
    store_t               bytes;
  } packet_t;

  typedef struct packed {
    logic [FLAG_W-1:0]                  error_flags;
    logic [FLAG_W-1:0]                  button_bits;
    logic [NUM_AXES-1:0][AXIS_W-1:0]    axes;   // x, y, z, rx, ry, rz from index 0
    kind_t                              kind;
  } result_t;

endpackage

// ===== hdl/sspd_collect.sv =====
// Packet collector: byte count, running check and the store of leading bytes.
module sspd_collect #(
  parameter int MAX_PACKET_BYTES = sspd_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           take,
  input  logic [sspd_pkg::IN_TDATA_W-1:0] rx_byte,
  output sspd_pkg::packet_t              packet
);

  logic [sspd_pkg::COUNT_W-1:0] count, count_next;
  logic [sspd_pkg::BYTE_W-1:0]  check, check_next;
  sspd_pkg::store_t             store;
  logic                         start;
  logic [sspd_pkg::COUNT_W-1:0] count_base;
  logic [sspd_pkg::BYTE_W-1:0]  check_base;
  logic [sspd_pkg::BYTE_W-1:0]  value;
  logic                         room;
  logic                         keep;

  assign start = ~rx_byte[7];
  assign value = rx_byte[sspd_pkg::BYTE_W-1:0];
  assign count_base = start ? '0 : count;
  assign check_base = start ? '0 : check;
  assign room = count_base < sspd_pkg::COUNT_W'(MAX_PACKET_BYTES);
  assign keep = room && (count_base < sspd_pkg::COUNT_W'(sspd_pkg::STORE_DEPTH));

  always_comb begin
    count_next = count;
    check_next = check;
    if (take) begin
      count_next = count_base;
      check_next = check_base;
      if (room) begin
        count_next = count_base + 1'b1;
        check_next = check_base ^ value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      check <= '0;
    end else begin
      count <= count_next;
      check <= check_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && keep) begin
      store[count_base[sspd_pkg::STORE_IDX_W-1:0]] <= value;
    end
  end

  assign packet.close = take && start && (count != '0);
  assign packet.count = count;
  assign packet.check = check;
  assign packet.bytes = store;

endmodule

// ===== hdl/sspd_decode.sv =====
// Packet decoder and result register.
module sspd_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                out_free,
  input  sspd_pkg::packet_t   packet,
  output logic                res_valid,
  output sspd_pkg::result_t   res
);

  logic [sspd_pkg::STORE_DEPTH-1:0][sspd_pkg::BYTE_W-1:0] d;
  sspd_pkg::result_t res_next;
  logic              hit;
  logic              sound;

  always_comb begin
    d = packet.bytes;
    for (int i = 0; i < sspd_pkg::KEY_LEN; i++) begin
      d[i + 2] = packet.bytes[i + 2] ^ sspd_pkg::MOTION_KEY[i];
    end
  end

  assign sound = (packet.count >= sspd_pkg::LEN_MIN) && (packet.check == '0);

  always_comb begin
    res_next = '0;
    hit = 1'b0;
    unique case (packet.bytes[0])
      sspd_pkg::TYPE_RESET: begin
        hit = 1'b1;
        res_next.kind = sspd_pkg::KIND_RESET;
      end
      sspd_pkg::TYPE_MOTION: begin
        hit = (packet.count == sspd_pkg::LEN_MOTION);
        res_next.kind = sspd_pkg::KIND_MOTION;
        res_next.axes[0] = {d[2], d[3][6:4]};
        res_next.axes[1] = {d[3][3:0], d[4][6:1]};
        res_next.axes[2] = {d[4][0], d[5], d[4][6:5]};
        res_next.axes[3] = {d[6][4:0], d[7][6:2]};
        res_next.axes[4] = {d[7][1:0], d[8], d[7][6]};
        res_next.axes[5] = {d[9][5:0], d[10][6:3]};
        res_next.button_bits = {1'b0, packet.bytes[1][5:0]};
      end
      sspd_pkg::TYPE_KEYS: begin
        hit = (packet.count == sspd_pkg::LEN_KEYS);
        res_next.kind = sspd_pkg::KIND_KEYS;
        res_next.button_bits = packet.bytes[2];
      end
      sspd_pkg::TYPE_ERROR: begin
        hit = (packet.count == sspd_pkg::LEN_ERROR);
        res_next.kind = sspd_pkg::KIND_ERROR;
        res_next.error_flags = packet.bytes[1];
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= packet.close && sound && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && packet.close) begin
      res <= res_next;
    end
  end

endmodule

// ===== hdl/six_axis_serial_packet_decoder.sv =====
// Top level of the six-axis serial packet decoder.
// Throughput: one byte transfer per cycle whenever the result side is not stalled.
// A packet's result is presented in the cycle after the start byte that closes it.
// The result register frees itself on the cycle its transfer completes, so input never waits
// on an empty or draining result register.
// Reset (rst, synchronous, active high) empties the result register and clears count and check.
module six_axis_serial_packet_decoder #(
  parameter int MAX_PACKET_BYTES = sspd_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [sspd_pkg::IN_TDATA_W-1:0]   s_tdata,   // [7:0] rx_byte
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [9:0] axis_x, [19:10] axis_y, [29:20] axis_z, [39:30] axis_rx, [49:40] axis_ry,
  // [59:50] axis_rz, [66:60] button_bits, [73:67] error_flags, [79:74] zero
  output logic [sspd_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic [sspd_pkg::OUT_TUSER_W-1:0]  m_tuser    // [1:0] packet_kind
);

  localparam int DATA_W = 2 * sspd_pkg::FLAG_W + sspd_pkg::NUM_AXES * sspd_pkg::AXIS_W;

  logic              out_free;
  logic              take;
  sspd_pkg::packet_t packet;
  sspd_pkg::result_t res;

  // The result register can load when it is empty or its transfer completes in this cycle.
  assign out_free = ~m_tvalid | m_tready;
  assign s_tready = out_free;
  assign take = s_tvalid & s_tready;

  // Count, running check and the first twelve bytes of the open packet.
  sspd_collect #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_collect (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .rx_byte(s_tdata),
    .packet (packet)
  );

  // A start byte closes the packet; its decoded result is registered at the same edge.
  sspd_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .out_free (out_free),
    .packet   (packet),
    .res_valid(m_tvalid),
    .res      (res)
  );

  // The packet kind travels beside the data; the other fields keep their struct order,
  // with the axes in the lowest bits.
  assign m_tuser = res.kind;
  assign m_tdata = {{(sspd_pkg::OUT_TDATA_W - DATA_W){1'b0}},
                    res.error_flags, res.button_bits, res.axes};

  // A continuation byte never closes a packet, so the result register empties behind it.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tdata[7]) |=> !m_tvalid)
    else $error("result produced by a continuation byte");

  // Input is taken exactly when the result register has room.
  assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow result register room");

  // A reset notice carries nothing beside its kind.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == sspd_pkg::KIND_RESET) |-> (m_tdata[73:0] == '0))
    else $error("reset notice with non-zero fields");

  // A motion result has six buttons and no error flags.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == sspd_pkg::KIND_MOTION) |->
      (m_tdata[73:66] == '0))
    else $error("motion result with stray button or error bits");

endmodule

// ===== dv/sspd_result_checker.sv =====
// Checker for the six-axis serial packet decoder: predicts each packet's result and compares it.
module sspd_result_checker
  import sspd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic [OUT_TUSER_W-1:0] m_tuser,
  output int                     mismatches,
  output int                     outstanding,
  output int                     results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;
  localparam int DATA_W = $bits(result_t) - $bits(kind_t);

  // Predicted state of the packet being collected.
  int unsigned      pkt_len;
  logic [BYTE_W-1:0] pkt_xor;
  logic [BYTE_W-1:0] pkt_store [STORE_DEPTH];

  result_t awaited_results[$];
  int      fail_tally;
  int      checked_tally;
  int      awaited_n;

  assign mismatches   = fail_tally;
  assign outstanding  = awaited_n;
  assign results_seen = checked_tally;

  // Decodes the packet just closed; returns 1 when it yields a result.
  function automatic bit decode_closed(output result_t r);
    logic [BYTE_W-1:0] d [STORE_DEPTH];
    r = '0;
    if (pkt_len < LEN_MIN || pkt_xor != '0) return 1'b0;
    d = pkt_store;
    case (pkt_store[0])
      TYPE_RESET: begin
        r.kind = KIND_RESET;
        return 1'b1;
      end
      TYPE_MOTION: begin
        if (pkt_len != LEN_MOTION) return 1'b0;
        for (int i = 0; i < KEY_LEN; i++) d[i+2] = pkt_store[i+2] ^ MOTION_KEY[i];
        r.kind    = KIND_MOTION;
        r.axes[0] = {d[2], d[3][6:4]};
        r.axes[1] = {d[3][3:0], d[4][6:1]};
        r.axes[2] = {d[4][0], d[5], d[4][6:5]};
        r.axes[3] = {d[6][4:0], d[7][6:2]};
        r.axes[4] = {d[7][1:0], d[8], d[7][6]};
        r.axes[5] = {d[9][5:0], d[10][6:3]};
        r.button_bits = {1'b0, d[1][5:0]};
        return 1'b1;
      end
      TYPE_KEYS: begin
        if (pkt_len != LEN_KEYS) return 1'b0;
        r.kind = KIND_KEYS;
        r.button_bits = pkt_store[2];
        return 1'b1;
      end
      TYPE_ERROR: begin
        if (pkt_len != LEN_ERROR) return 1'b0;
        r.kind = KIND_ERROR;
        r.error_flags = pkt_store[1];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic absorb_byte(input logic [IN_TDATA_W-1:0] b);
    result_t r;
    if (!b[7]) begin
      if (pkt_len != 0 && decode_closed(r)) awaited_results.push_back(r);
      pkt_len = 0;
      pkt_xor = '0;
    end
    // Bytes past the packet limit are dropped outright.
    if (pkt_len < MAX_PACKET_BYTES_DEF) begin
      if (pkt_len < STORE_DEPTH) pkt_store[pkt_len] = b[6:0];
      pkt_xor = pkt_xor ^ b[6:0];
      pkt_len++;
    end
  endtask

  function automatic string show(input result_t r);
    return $sformatf("kind %0d axes %0d %0d %0d %0d %0d %0d buttons %h flags %h",
                     r.kind, $signed(r.axes[0]), $signed(r.axes[1]), $signed(r.axes[2]),
                     $signed(r.axes[3]), $signed(r.axes[4]), $signed(r.axes[5]),
                     r.button_bits, r.error_flags);
  endfunction

  task automatic compare_result(input logic [OUT_TDATA_W-1:0] word,
                                input logic [OUT_TUSER_W-1:0] user);
    result_t got;
    result_t want;
    bit      bad;
    got = result_t'({word[DATA_W-1:0], user});
    checked_tally++;
    if (awaited_results.size() == 0) begin
      fail_tally++;
      if (fail_tally <= REPORT_LIMIT)
        $display("[%0t] result with none awaited: %s", $realtime, show(got));
    end else begin
      want = awaited_results.pop_front();
      bad = (got.kind != want.kind) || (got.button_bits != want.button_bits) ||
            (got.error_flags != want.error_flags) ||
            (word[OUT_TDATA_W-1:DATA_W] != '0);
      for (int i = 0; i < NUM_AXES; i++) bad |= (got.axes[i] != want.axes[i]);
      if (bad) begin
        fail_tally++;
        if (fail_tally <= REPORT_LIMIT) begin
          $display("[%0t] result %0d differs", $realtime, checked_tally);
          $display("  expected %s", show(want));
          $display("  actual   %s pad %h", show(got), word[OUT_TDATA_W-1:DATA_W]);
        end
      end
    end
  endtask

  initial begin
    fail_tally    = 0;
    checked_tally = 0;
    awaited_n     = 0;
    pkt_len       = 0;
    pkt_xor       = '0;
    pkt_store     = '{default: '0};
  end

  always @(posedge clk) begin
    if (rst) begin
      pkt_len = 0;
      pkt_xor = '0;
      awaited_results.delete();
    end else begin
      // A result leaves from the result register, after its closing byte was taken, so compare first.
      if (m_tvalid && m_tready) compare_result(m_tdata, m_tuser);
      if (s_tvalid && s_tready) absorb_byte(s_tdata);
    end
    awaited_n = awaited_results.size();
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the six-axis serial packet decoder: byte stimulus, flow control and verdict.
module tb;
  import sspd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BYTE_TARGET = 1550;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 20;

  typedef logic [BYTE_W-1:0] sym_q_t[$];

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [7:0] rx_byte
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // [59:0] six axes, [66:60] buttons, [73:67] error flags, [79:74] zero
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;        // [1:0] packet kind

  int mismatches;
  int outstanding;
  int results_seen;

  // Percentages of cycles in which each side holds back; changed per phase.
  int sender_idle = 6;
  int recv_idle = 61;

  int bytes_sent = 0;
  int packets_sent = 0;
  int sound_packets = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  six_axis_serial_packet_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  sspd_result_checker decode_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  // The result side stalls at random, cycle by cycle, at the rate of the current phase.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  // A hung handshake must not keep the run going forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("six_axis_serial_packet_decoder: mismatch");
      $finish;
    end
  end

  // Offers one byte from a falling edge and returns on the falling edge after its transfer.
  // Idle cycles are inserted in front of the byte, so gaps land anywhere within a packet.
  task automatic send_byte(input logic [IN_TDATA_W-1:0] b);
    while ($urandom_range(99) < sender_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // The first symbol goes out as a start byte (bit 7 clear), the rest as continuation bytes.
  task automatic send_packet(input sym_q_t body);
    foreach (body[i]) send_byte({i != 0, body[i]});
    packets_sent++;
  endtask

  // Appends the symbol that brings the XOR of the whole packet to zero.
  function automatic sym_q_t with_check(input sym_q_t body);
    logic [BYTE_W-1:0] chk;
    chk = '0;
    foreach (body[i]) chk ^= body[i];
    body.push_back(chk);
    return body;
  endfunction

  // A packet of the given type and total length, random content and a valid check.
  function automatic sym_q_t random_packet(input logic [BYTE_W-1:0] kind_byte, input int len);
    sym_q_t body;
    body.push_back(kind_byte);
    repeat (len - 2) body.push_back(BYTE_W'($urandom_range(127)));
    return with_check(body);
  endfunction

  function automatic logic [BYTE_W-1:0] known_type(input int pick);
    case (pick % 4)
      0:       return TYPE_MOTION;
      1:       return TYPE_KEYS;
      2:       return TYPE_ERROR;
      default: return TYPE_RESET;
    endcase
  endfunction

  function automatic int proper_len(input logic [BYTE_W-1:0] kind_byte);
    case (kind_byte)
      TYPE_MOTION: return LEN_MOTION;
      TYPE_KEYS:   return LEN_KEYS;
      TYPE_ERROR:  return LEN_ERROR;
      default:     return $urandom_range(2, 20);
    endcase
  endfunction

  // A motion packet built from the descrambled axis bytes, so axis values can be aimed at.
  task automatic send_motion(input logic [BYTE_W-1:0] buttons,
                             input logic [BYTE_W-1:0] plain [KEY_LEN]);
    sym_q_t body;
    body.push_back(TYPE_MOTION);
    body.push_back(buttons);
    for (int i = 0; i < KEY_LEN; i++) body.push_back(plain[i] ^ MOTION_KEY[i]);
    send_packet(with_check(body));
  endtask

  // One random packet: mostly well formed, the rest broken in one way or another.
  task automatic send_random_packet();
    sym_q_t            body;
    logic [BYTE_W-1:0] kind_byte;
    logic [BYTE_W-1:0] plain [KEY_LEN];
    int                sel;
    int                len;
    int                off;
    sel = $urandom_range(99);
    if (sel < 30) begin
      foreach (plain[i]) plain[i] = BYTE_W'($urandom_range(127));
      send_motion(BYTE_W'($urandom_range(127)), plain);
      sound_packets++;
    end else if (sel < 70) begin
      kind_byte = (sel < 45) ? TYPE_KEYS : (sel < 60) ? TYPE_ERROR : TYPE_RESET;
      send_packet(random_packet(kind_byte, proper_len(kind_byte)));
      sound_packets++;
    end else if (sel < 78) begin
      // Checked correctly, but one to three bytes off the length its type needs.
      kind_byte = known_type($urandom_range(2));
      off = $urandom_range(1, 3);
      len = $urandom_range(1) ? proper_len(kind_byte) + off : proper_len(kind_byte) - off;
      if (len < 2) len = 2;
      send_packet(random_packet(kind_byte, len));
    end else if (sel < 85) begin
      // Right length, broken check.
      kind_byte = known_type($urandom_range(3));
      body = random_packet(kind_byte, proper_len(kind_byte));
      body[body.size()-1] = body[body.size()-1] ^ BYTE_W'($urandom_range(1, 127));
      send_packet(body);
    end else if (sel < 91) begin
      do kind_byte = BYTE_W'($urandom_range(127));
      while (kind_byte == TYPE_MOTION || kind_byte == TYPE_KEYS ||
             kind_byte == TYPE_ERROR || kind_byte == TYPE_RESET);
      send_packet(random_packet(kind_byte, $urandom_range(2, 14)));
    end else if (sel < 95) begin
      // A lone start byte is too short to decode.
      body.push_back(known_type($urandom_range(3)));
      send_packet(body);
    end else if (sel < 97) begin
      // Overlong: the first full packet's worth checks out, the tail must be dropped.
      kind_byte = $urandom_range(3) == 0 ? TYPE_MOTION : TYPE_RESET;
      body = random_packet(kind_byte, MAX_PACKET_BYTES_DEF);
      repeat ($urandom_range(1, 8)) body.push_back(BYTE_W'($urandom_range(127)));
      send_packet(body);
      if (kind_byte == TYPE_RESET) sound_packets++;
    end else begin
      repeat ($urandom_range(1, 6)) send_byte(IN_TDATA_W'($urandom_range(255)));
    end
  endtask

  initial begin
    sym_q_t body;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Continuation bytes straight after reset open a packet of their own: two copies of the
    // reset type byte give a valid reset notice once the next start byte closes them.
    send_byte({1'b1, TYPE_RESET});
    send_byte({1'b1, TYPE_RESET});

    // Motion packet aimed at the axis extremes: X and RZ at the top, RX at the bottom.
    send_motion(7'h3f, '{7'h3f, 7'h7f, 7'h00, 7'h00, 7'h10, 7'h00, 7'h7f, 7'h1f, 7'h7f});

    // Every button and every error flag set.
    body = {TYPE_KEYS, 7'h00, 7'h7f, 7'h00};
    send_packet(with_check(body));
    body = {TYPE_ERROR, 7'h7f, 7'h00};
    send_packet(with_check(body));
    sound_packets += 4;

    // Random traffic in three flow-control phases: a slow receiver, then a slow sender,
    // then neither holding back.
    while (bytes_sent < BYTE_TARGET) begin
      if (bytes_sent < BYTE_TARGET / 3) begin
        sender_idle = 6;
        recv_idle = 61;
      end else if (bytes_sent < 2 * BYTE_TARGET / 3) begin
        sender_idle = 61;
        recv_idle = 6;
      end else begin
        sender_idle = 0;
        recv_idle = 0;
      end
      send_random_packet();
    end

    // A final start byte closes the last packet so its result is produced too.
    send_byte({1'b0, 7'h00});
    s_tvalid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d bytes in %0d packets (%0d well formed), checked %0d results.",
             bytes_sent, packets_sent, sound_packets, results_seen);
    $display("Covered all packet types, bad checks, wrong lengths, overlong and noise bytes.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("six_axis_serial_packet_decoder: match");
    end else begin
      $display("six_axis_serial_packet_decoder: mismatch");
    end
    $finish;
  end

endmodule
